@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the scheduler datapath.
// Depends on nothing; assertions are compiled out when SYNTHESIS is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define DHRS_ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");
`define DHRS_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`else
`define DHRS_ASSERT_ALWAYS(lbl, clk, rst, expr)
`define DHRS_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`endif
`endif

@@ rtl/core/dhrs_pkg.sv @@
// Types and constants of the disk head request scheduler.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps
package dhrs_pkg;
   localparam int ID_W   = 7;
   localparam int ARR_W  = 17;
   localparam int TRK_W  = 14;
   localparam int TIME_W = 21;
   localparam int SUM_W  = 28;
   localparam int POL_W  = 3;

   localparam logic [POL_W-1:0] POL_FIFO  = 3'd0;
   localparam logic [POL_W-1:0] POL_SSTF  = 3'd1;
   localparam logic [POL_W-1:0] POL_LOOK  = 3'd2;
   localparam logic [POL_W-1:0] POL_CLOOK = 3'd3;
   localparam logic [POL_W-1:0] POL_FLOOK = 3'd4;

   localparam logic OP_SUBMIT = 1'b0;
   localparam logic OP_STEP   = 1'b1;

   localparam logic REG_POLICY      = 1'b0;
   localparam logic REG_START_TRACK = 1'b1;

   localparam logic [1:0] OUT_IDLE     = 2'd0;
   localparam logic [1:0] OUT_SERVICE  = 2'd1;
   localparam logic [1:0] OUT_FINISHED = 2'd2;

   typedef struct packed {
      logic [ID_W-1:0]  id;
      logic [ARR_W-1:0] arr;
      logic [TRK_W-1:0] trk;
   } entry_type;

   typedef enum logic [3:0] {
      S_IDLE, S_ADM_RD, S_ADM_CHK, S_SWAP_CHK, S_SWAP,
      S_DECIDE, S_SCAN, S_SERVE, S_COMPACT
   } state_type;

   typedef enum logic [1:0] {P_SWAP, P_SCAN, P_COMP} pipe_kind_type;
   typedef enum logic [1:0] {M_FIRST, M_NEAR, M_DIR, M_MIN} scan_mode_type;

   typedef struct packed {
      logic          submit;
      logic          begin_step;
      logic          fut_rd;
      logic          admit;
      logic          pipe_start;
      logic          pipe_run;
      pipe_kind_type kind;
      scan_mode_type mode;
      logic          swap_done;
      logic          flip_dir;
      logic          emit_idle;
      logic          emit_fin;
      logic          serve;
      logic          compact_done;
   } cmd_type;

   typedef struct packed {
      logic fut_pending;
      logic fut_due;
      logic act_empty;
      logic stg_empty;
      logic pipe_done;
      logic best_valid;
   } status_type;

   typedef struct packed {
      logic [1:0]        outcome;
      logic [ID_W-1:0]   served_id;
      logic [TIME_W-1:0] start_time;
      logic [TIME_W-1:0] end_time;
      logic [TRK_W-1:0]  from_track;
      logic [TRK_W-1:0]  to_track;
      logic [TIME_W-1:0] wait_time;
      logic              sweep_down;
      logic [TIME_W-1:0] total_movement;
      logic [SUM_W-1:0]  total_wait;
      logic [SUM_W-1:0]  total_turnaround;
      logic [TIME_W-1:0] max_wait_seen;
   } rsp_type;
endpackage

@@ rtl/core/disk_head_request_scheduler.sv @@
// Top level of the disk head request scheduler: configuration registers,
// sequencer and datapath. Depends on dhrs_pkg, dhrs_ctrl and dhrs_datapath.
//
//   Channel   Handshake             Word
//   req_*     start & !busy         operation, request_id, arrival_time, track
//   rsp_*     rsp_strobe, 1 cycle   outcome, ids, times, tracks, totals
//   csr_*     csr_valid & ready     csr_index (0 policy, 1 start track), wdata
//
// A submit is taken in the idle state; busy stays low. A step admits each due
// request through a read state and a check state, moves a staged list in,
// makes one pass over the active list (a second pass when a LOOK or F-LOOK
// sweep turns or C-LOOK wraps), then serves one request and compacts the list.
// Each list memory has a single read port. Reset is synchronous and clears all
// control state; memories are not cleared. The result receiver cannot stall
// the block.
`timescale 1ns / 1ps
module disk_head_request_scheduler #(
   parameter int MAX_REQUESTS = 128,
   parameter int TRACK_LIMIT  = 9999
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_operation,
   input  logic [dhrs_pkg::ID_W-1:0]     req_request_id,
   input  logic [dhrs_pkg::ARR_W-1:0]    req_arrival_time,
   input  logic [dhrs_pkg::TRK_W-1:0]    req_request_track,
   output logic                          rsp_strobe,
   output logic [1:0]                    rsp_outcome,
   output logic [dhrs_pkg::ID_W-1:0]     rsp_served_id,
   output logic [dhrs_pkg::TIME_W-1:0]   rsp_start_time,
   output logic [dhrs_pkg::TIME_W-1:0]   rsp_end_time,
   output logic [dhrs_pkg::TRK_W-1:0]    rsp_from_track,
   output logic [dhrs_pkg::TRK_W-1:0]    rsp_to_track,
   output logic [dhrs_pkg::TIME_W-1:0]   rsp_wait_time,
   output logic                          rsp_sweep_down,
   output logic [dhrs_pkg::TIME_W-1:0]   rsp_total_movement,
   output logic [dhrs_pkg::SUM_W-1:0]    rsp_total_wait,
   output logic [dhrs_pkg::SUM_W-1:0]    rsp_total_turnaround,
   output logic [dhrs_pkg::TIME_W-1:0]   rsp_max_wait_seen,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic                          csr_index,
   input  logic [dhrs_pkg::TRK_W-1:0]    csr_wdata
);
   import dhrs_pkg::*;

   logic [POL_W-1:0] policy_ff;
   logic [TRK_W-1:0] start_track_ff;
   cmd_type          cmd;
   status_type       status;
   rsp_type          rsp;
   logic             start_ok;

   assign csr_ready = 1'b1;
   assign start_ok  = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff      <= POL_FIFO;
         start_track_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == REG_POLICY) begin
            policy_ff <= csr_wdata[POL_W-1:0];
         end else begin
            start_track_ff <= csr_wdata;
         end
      end
   end

   dhrs_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start_ok),
      .req_operation (req_operation),
      .policy        (policy_ff),
      .status        (status),
      .cmd           (cmd),
      .busy          (busy)
   );

   dhrs_datapath #(
      .MAX_REQUESTS (MAX_REQUESTS),
      .TRACK_LIMIT  (TRACK_LIMIT)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .policy            (policy_ff),
      .start_track       (start_track_ff),
      .req_request_id    (req_request_id),
      .req_arrival_time  (req_arrival_time),
      .req_request_track (req_request_track),
      .status            (status),
      .rsp               (rsp),
      .rsp_strobe        (rsp_strobe)
   );

   assign rsp_outcome          = rsp.outcome;
   assign rsp_served_id        = rsp.served_id;
   assign rsp_start_time       = rsp.start_time;
   assign rsp_end_time         = rsp.end_time;
   assign rsp_from_track       = rsp.from_track;
   assign rsp_to_track         = rsp.to_track;
   assign rsp_wait_time        = rsp.wait_time;
   assign rsp_sweep_down       = rsp.sweep_down;
   assign rsp_total_movement   = rsp.total_movement;
   assign rsp_total_wait       = rsp.total_wait;
   assign rsp_total_turnaround = rsp.total_turnaround;
   assign rsp_max_wait_seen    = rsp.max_wait_seen;
endmodule

@@ rtl/core/dhrs_ctrl.sv @@
// Sequencer of the scheduler: admission, list swap, scan, service, compaction.
// Depends on dhrs_pkg; drives the datapath through cmd_type.
`timescale 1ns / 1ps
module dhrs_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic                         req_operation,
   input  logic [dhrs_pkg::POL_W-1:0]   policy,
   input  dhrs_pkg::status_type         status,
   output dhrs_pkg::cmd_type            cmd,
   output logic                         busy
);
   import dhrs_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd      = '0;
      cmd.kind = P_SCAN;
      cmd.mode = M_FIRST;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (req_operation == OP_STEP) begin
                  cmd.begin_step = 1'b1;
                  state_in = S_ADM_RD;
               end else begin
                  cmd.submit = 1'b1;
               end
            end
         end
         S_ADM_RD: begin
            if (status.fut_pending) begin
               cmd.fut_rd = 1'b1;
               state_in = S_ADM_CHK;
            end else begin
               state_in = S_SWAP_CHK;
            end
         end
         S_ADM_CHK: begin
            if (status.fut_due) begin
               cmd.admit = 1'b1;
               state_in = S_ADM_RD;
            end else begin
               state_in = S_SWAP_CHK;
            end
         end
         S_SWAP_CHK: begin
            if (status.act_empty && !status.stg_empty) begin
               cmd.pipe_start = 1'b1;
               cmd.kind = P_SWAP;
               state_in = S_SWAP;
            end else begin
               state_in = S_DECIDE;
            end
         end
         S_SWAP: begin
            if (status.pipe_done) begin
               cmd.swap_done = 1'b1;
               state_in = S_DECIDE;
            end else begin
               cmd.pipe_run = 1'b1;
               cmd.kind = P_SWAP;
            end
         end
         S_DECIDE: begin
            if (status.act_empty) begin
               if (status.fut_pending) begin
                  cmd.emit_idle = 1'b1;
               end else begin
                  cmd.emit_fin = 1'b1;
               end
               state_in = S_IDLE;
            end else begin
               cmd.pipe_start = 1'b1;
               cmd.kind = P_SCAN;
               if (policy == POL_SSTF) begin
                  cmd.mode = M_NEAR;
               end else if (policy == POL_LOOK || policy == POL_FLOOK ||
                            policy == POL_CLOOK) begin
                  cmd.mode = M_DIR;
               end else begin
                  cmd.mode = M_FIRST;
               end
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.kind = P_SCAN;
            if (status.pipe_done) begin
               if (status.best_valid) begin
                  state_in = S_SERVE;
               end else if (policy == POL_CLOOK) begin
                  // Nothing above the head: wrap to the lowest track.
                  cmd.pipe_start = 1'b1;
                  cmd.mode = M_MIN;
               end else begin
                  // End of the sweep: reverse and look again.
                  cmd.flip_dir = 1'b1;
                  cmd.pipe_start = 1'b1;
                  cmd.mode = M_DIR;
               end
            end else begin
               cmd.pipe_run = 1'b1;
            end
         end
         S_SERVE: begin
            cmd.serve = 1'b1;
            cmd.pipe_start = 1'b1;
            cmd.kind = P_COMP;
            state_in = S_COMPACT;
         end
         S_COMPACT: begin
            cmd.kind = P_COMP;
            if (status.pipe_done) begin
               cmd.compact_done = 1'b1;
               state_in = S_IDLE;
            end else begin
               cmd.pipe_run = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != S_IDLE);
endmodule

@@ rtl/core/dhrs_datapath.sv @@
// Datapath of the scheduler: request memories, counters, head and time state,
// the scan and copy pipeline, and the result register. Depends on dhrs_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dhrs_datapath #(
   parameter int MAX_REQUESTS = 128,
   parameter int TRACK_LIMIT  = 9999
) (
   input  logic                          clock,
   input  logic                          reset,
   input  dhrs_pkg::cmd_type             cmd,
   input  logic [dhrs_pkg::POL_W-1:0]    policy,
   input  logic [dhrs_pkg::TRK_W-1:0]    start_track,
   input  logic [dhrs_pkg::ID_W-1:0]     req_request_id,
   input  logic [dhrs_pkg::ARR_W-1:0]    req_arrival_time,
   input  logic [dhrs_pkg::TRK_W-1:0]    req_request_track,
   output dhrs_pkg::status_type          status,
   output dhrs_pkg::rsp_type             rsp,
   output logic                          rsp_strobe
);
   import dhrs_pkg::*;

   localparam int IW = $clog2(MAX_REQUESTS);
   localparam int CW = $clog2(MAX_REQUESTS + 1);

   entry_type fut_mem [0:MAX_REQUESTS-1];
   entry_type act_mem [0:MAX_REQUESTS-1];
   entry_type stg_mem [0:MAX_REQUESTS-1];
   entry_type fut_q, act_q, stg_q;

   logic [CW-1:0] fut_fill_ff, fut_next_ff, act_cnt_ff, stg_cnt_ff;
   logic [TRK_W-1:0]  head_ff;
   logic              dir_ff, started_ff;
   logic [TIME_W-1:0] time_ff, mov_ff, wmax_ff;
   logic [SUM_W-1:0]  wsum_ff, tsum_ff;

   pipe_kind_type kind_ff;
   scan_mode_type mode_ff;
   logic [CW-1:0] iss_ff;
   logic          pv_ff;
   logic [IW-1:0] pidx_ff;

   logic              best_valid_ff;
   logic [IW-1:0]     best_idx_ff;
   entry_type         best_ff;
   logic [TRK_W-1:0]  best_metric_ff;

   rsp_type rsp_ff;
   logic    rsp_strobe_ff;

   function automatic logic [TRK_W-1:0] clamp_trk(input logic [TRK_W-1:0] t);
      if (t > TRACK_LIMIT) begin
         return TRK_W'(TRACK_LIMIT);
      end
      return t;
   endfunction

   function automatic logic [TRK_W-1:0] trk_dist(input logic [TRK_W-1:0] a,
                                                 input logic [TRK_W-1:0] b);
      return (a >= b) ? (a - b) : (b - a);
   endfunction

   // Pipeline control shared by swap, scan and compaction.
   logic [CW-1:0] limit;
   logic          can_issue, run_issue, run_use;
   assign limit     = (kind_ff == P_SWAP) ? stg_cnt_ff : act_cnt_ff;
   assign can_issue = (iss_ff < limit);
   assign run_issue = cmd.pipe_run && can_issue;
   assign run_use   = cmd.pipe_run && pv_ff;

   // Scan candidate evaluation on the registered read data.
   logic [TRK_W-1:0] cand_trk, cand_metric;
   logic             cand_ok, cand_better;
   always_comb begin
      cand_trk    = act_q.trk;
      cand_metric = (mode_ff == M_MIN) ? cand_trk : trk_dist(cand_trk, head_ff);
      case (mode_ff)
         M_FIRST: cand_ok = (pidx_ff == '0);
         M_NEAR:  cand_ok = 1'b1;
         M_DIR:   cand_ok = dir_ff ? (cand_trk <= head_ff) : (cand_trk >= head_ff);
         M_MIN:   cand_ok = 1'b1;
         default: cand_ok = 1'b0;
      endcase
      cand_better = cand_ok && (!best_valid_ff || (cand_metric < best_metric_ff));
   end

   // Service arithmetic.
   logic [TRK_W-1:0]  sv_d;
   logic [TIME_W:0]   sv_tsum, sv_msum;
   logic [TIME_W-1:0] sv_en, sv_arr, sv_w, sv_turn, sv_mov;
   logic [SUM_W:0]    sv_wsum, sv_tturn;
   logic [SUM_W-1:0]  sv_wsum_sat, sv_tsum_sat;
   always_comb begin
      sv_d    = trk_dist(head_ff, best_ff.trk);
      sv_tsum = {1'b0, time_ff} + (TIME_W + 1)'(sv_d);
      sv_en   = sv_tsum[TIME_W] ? '1 : sv_tsum[TIME_W-1:0];
      sv_arr  = TIME_W'(best_ff.arr);
      sv_w    = (time_ff >= sv_arr) ? (time_ff - sv_arr) : '0;
      sv_turn = (sv_en >= sv_arr) ? (sv_en - sv_arr) : '0;
      sv_msum = {1'b0, mov_ff} + (TIME_W + 1)'(sv_d);
      sv_mov  = sv_msum[TIME_W] ? '1 : sv_msum[TIME_W-1:0];
      sv_wsum = {1'b0, wsum_ff} + (SUM_W + 1)'(sv_w);
      sv_wsum_sat = sv_wsum[SUM_W] ? '1 : sv_wsum[SUM_W-1:0];
      sv_tturn = {1'b0, tsum_ff} + (SUM_W + 1)'(sv_turn);
      sv_tsum_sat = sv_tturn[SUM_W] ? '1 : sv_tturn[SUM_W-1:0];
   end

   // Memories.
   entry_type sub_entry;
   assign sub_entry = '{id: req_request_id, arr: req_arrival_time,
                        trk: clamp_trk(req_request_track)};

   always_ff @(posedge clock) begin
      if (cmd.submit && (fut_fill_ff < CW'(MAX_REQUESTS))) begin
         fut_mem[fut_fill_ff[IW-1:0]] <= sub_entry;
      end
      if (cmd.fut_rd) begin
         fut_q <= fut_mem[fut_next_ff[IW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.admit && (policy == POL_FLOOK)) begin
         stg_mem[stg_cnt_ff[IW-1:0]] <= fut_q;
      end
      if (run_issue && (kind_ff == P_SWAP)) begin
         stg_q <= stg_mem[iss_ff[IW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.admit && (policy != POL_FLOOK)) begin
         act_mem[act_cnt_ff[IW-1:0]] <= fut_q;
      end else if (run_use && (kind_ff == P_SWAP)) begin
         act_mem[pidx_ff] <= stg_q;
      end else if (run_use && (kind_ff == P_COMP)) begin
         act_mem[pidx_ff - IW'(1)] <= act_q;
      end
      if (run_issue && (kind_ff != P_SWAP)) begin
         act_q <= act_mem[iss_ff[IW-1:0]];
      end
   end

   // Pipeline and scan registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff         <= 1'b0;
         iss_ff        <= '0;
         kind_ff       <= P_SCAN;
         mode_ff       <= M_FIRST;
         best_valid_ff <= 1'b0;
      end else if (cmd.pipe_start) begin
         kind_ff <= cmd.kind;
         mode_ff <= cmd.mode;
         pv_ff   <= 1'b0;
         iss_ff  <= (cmd.kind == P_COMP) ? (CW'(best_idx_ff) + CW'(1)) : '0;
         if (cmd.kind == P_SCAN) begin
            best_valid_ff <= 1'b0;
         end
      end else if (cmd.pipe_run) begin
         pv_ff <= can_issue;
         if (can_issue) begin
            iss_ff  <= iss_ff + CW'(1);
            pidx_ff <= iss_ff[IW-1:0];
         end
         if (pv_ff && (kind_ff == P_SCAN) && cand_better) begin
            best_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (run_use && (kind_ff == P_SCAN) && cand_better) begin
         best_idx_ff    <= pidx_ff;
         best_ff        <= act_q;
         best_metric_ff <= cand_metric;
      end
   end

   // Counters, head, time and totals.
   always_ff @(posedge clock) begin
      if (reset) begin
         fut_fill_ff <= '0;
         fut_next_ff <= '0;
         act_cnt_ff  <= '0;
         stg_cnt_ff  <= '0;
         head_ff     <= '0;
         dir_ff      <= 1'b0;
         started_ff  <= 1'b0;
         time_ff     <= '0;
         mov_ff      <= '0;
         wsum_ff     <= '0;
         tsum_ff     <= '0;
         wmax_ff     <= '0;
      end else begin
         if (cmd.submit && (fut_fill_ff < CW'(MAX_REQUESTS))) begin
            fut_fill_ff <= fut_fill_ff + CW'(1);
         end
         if (cmd.begin_step && !started_ff) begin
            head_ff    <= clamp_trk(start_track);
            started_ff <= 1'b1;
         end
         if (cmd.admit) begin
            fut_next_ff <= fut_next_ff + CW'(1);
            if (policy == POL_FLOOK) begin
               stg_cnt_ff <= stg_cnt_ff + CW'(1);
            end else begin
               act_cnt_ff <= act_cnt_ff + CW'(1);
            end
         end
         if (cmd.swap_done) begin
            act_cnt_ff <= stg_cnt_ff;
            stg_cnt_ff <= '0;
         end
         if (cmd.flip_dir) begin
            dir_ff <= ~dir_ff;
         end
         if (cmd.emit_idle) begin
            time_ff <= TIME_W'(fut_q.arr);
         end
         if (cmd.serve) begin
            head_ff <= best_ff.trk;
            time_ff <= sv_en;
            mov_ff  <= sv_mov;
            wsum_ff <= sv_wsum_sat;
            tsum_ff <= sv_tsum_sat;
            if (sv_w > wmax_ff) begin
               wmax_ff <= sv_w;
            end
         end
         if (cmd.compact_done) begin
            act_cnt_ff <= act_cnt_ff - CW'(1);
         end
      end
   end

   // Result word.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.emit_idle || cmd.emit_fin || cmd.serve;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.serve) begin
         rsp_ff.outcome          <= OUT_SERVICE;
         rsp_ff.served_id        <= best_ff.id;
         rsp_ff.start_time       <= time_ff;
         rsp_ff.end_time         <= sv_en;
         rsp_ff.from_track       <= head_ff;
         rsp_ff.to_track         <= best_ff.trk;
         rsp_ff.wait_time        <= sv_w;
         rsp_ff.sweep_down       <= dir_ff;
         rsp_ff.total_movement   <= sv_mov;
         rsp_ff.total_wait       <= sv_wsum_sat;
         rsp_ff.total_turnaround <= sv_tsum_sat;
         rsp_ff.max_wait_seen    <= (sv_w > wmax_ff) ? sv_w : wmax_ff;
      end else if (cmd.emit_idle || cmd.emit_fin) begin
         rsp_ff.outcome          <= cmd.emit_idle ? OUT_IDLE : OUT_FINISHED;
         rsp_ff.served_id        <= '0;
         rsp_ff.start_time       <= time_ff;
         rsp_ff.end_time         <= cmd.emit_idle ? TIME_W'(fut_q.arr) : time_ff;
         rsp_ff.from_track       <= head_ff;
         rsp_ff.to_track         <= head_ff;
         rsp_ff.wait_time        <= '0;
         rsp_ff.sweep_down       <= dir_ff;
         rsp_ff.total_movement   <= mov_ff;
         rsp_ff.total_wait       <= wsum_ff;
         rsp_ff.total_turnaround <= tsum_ff;
         rsp_ff.max_wait_seen    <= wmax_ff;
      end
   end

   assign rsp        = rsp_ff;
   assign rsp_strobe = rsp_strobe_ff;

   assign status.fut_pending = (fut_next_ff < fut_fill_ff);
   assign status.fut_due     = (TIME_W'(fut_q.arr) <= time_ff);
   assign status.act_empty   = (act_cnt_ff == '0);
   assign status.stg_empty   = (stg_cnt_ff == '0);
   assign status.pipe_done   = !can_issue && !pv_ff;
   assign status.best_valid  = best_valid_ff;

   `DHRS_ASSERT_ALWAYS(a_next_le_fill, clock, reset, fut_next_ff <= fut_fill_ff)
   `DHRS_ASSERT_ALWAYS(a_lists_le_admitted, clock, reset,
      ((CW + 1)'(act_cnt_ff) + (CW + 1)'(stg_cnt_ff)) <= (CW + 1)'(fut_next_ff))
   `DHRS_ASSERT_IMPLY(a_head_matches_rsp, clock, reset, rsp_strobe_ff,
      head_ff == rsp_ff.to_track)
endmodule

@@ bench/disk_head_request_scheduler_tb.sv @@
// Self-checking testbench for the disk head request scheduler.
// Depends on dhrs_pkg and disk_head_request_scheduler; it mirrors the scheduler
// in a cycle-free predictor and checks every reported event field by field.
`timescale 1ns / 1ps
module disk_head_request_scheduler_tb;
   import dhrs_pkg::*;

   localparam int          CAPACITY  = 128;
   localparam int unsigned TRACK_MAX = 9999;
   localparam int unsigned TIME_SAT  = 2097151;
   localparam int unsigned SUM_SAT   = 268435455;
   localparam int unsigned ARR_TOP   = 131071;
   localparam int          WATCHDOG  = 20000;

   typedef struct {
      logic              op;
      logic [ID_W-1:0]   id;
      logic [ARR_W-1:0]  arr;
      logic [TRK_W-1:0]  trk;
   } word_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic                req_operation = OP_SUBMIT;
   logic [ID_W-1:0]     req_request_id = '0;
   logic [ARR_W-1:0]    req_arrival_time = '0;
   logic [TRK_W-1:0]    req_request_track = '0;
   logic                rsp_strobe;
   rsp_type             seen;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic                csr_index = REG_POLICY;
   logic [TRK_W-1:0]    csr_wdata = '0;

   word_type            pending_words[$];
   rsp_type             expected_events[$];
   int                  idle_pct = 9;
   int                  fails = 0;
   int                  stall_cycles = 0;
   bit                  word_taken = 1'b0;
   bit                  csr_taken = 1'b0;

   // Mirror of the scheduler state.
   entry_type           future_q[CAPACITY];
   entry_type           active_q[CAPACITY];
   entry_type           staged_q[CAPACITY];
   int unsigned         future_fill, future_next, active_cnt, staged_cnt;
   int unsigned         head_trk, now_t, move_sum, wait_sum, turn_sum, wait_top;
   bit                  heading_down, run_begun;
   logic [POL_W-1:0]    policy_reg = POL_FIFO;
   logic [TRK_W-1:0]    start_trk_reg = '0;

   always #1 clock = ~clock;

   disk_head_request_scheduler i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_operation(req_operation), .req_request_id(req_request_id),
      .req_arrival_time(req_arrival_time), .req_request_track(req_request_track),
      .rsp_strobe(rsp_strobe), .rsp_outcome(seen.outcome),
      .rsp_served_id(seen.served_id), .rsp_start_time(seen.start_time),
      .rsp_end_time(seen.end_time), .rsp_from_track(seen.from_track),
      .rsp_to_track(seen.to_track), .rsp_wait_time(seen.wait_time),
      .rsp_sweep_down(seen.sweep_down), .rsp_total_movement(seen.total_movement),
      .rsp_total_wait(seen.total_wait), .rsp_total_turnaround(seen.total_turnaround),
      .rsp_max_wait_seen(seen.max_wait_seen),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   function automatic int unsigned clamp_trk(int unsigned t);
      return (t > TRACK_MAX) ? TRACK_MAX : t;
   endfunction

   function automatic int unsigned sat_sum(int unsigned a, int unsigned b, int unsigned lim);
      longint unsigned s;
      s = longint'(a) + longint'(b);
      return (s > lim) ? lim : 32'(s);
   endfunction

   function automatic int unsigned gap(int unsigned a, int unsigned b);
      return (a > b) ? a - b : b - a;
   endfunction

   // Closest active request; on a sweep only requests on the current side count.
   function automatic int closest_request(bit on_sweep);
      int          best;
      int unsigned best_d, t, d;
      best = -1;
      best_d = 0;
      for (int i = 0; i < active_cnt; i++) begin
         t = 32'(active_q[i].trk);
         if (on_sweep && !heading_down && t < head_trk) continue;
         if (on_sweep && heading_down && t > head_trk) continue;
         d = gap(t, head_trk);
         if (best < 0 || d < best_d) begin
            best = i;
            best_d = d;
         end
      end
      return best;
   endfunction

   function automatic bit schedule_word(word_type w, output rsp_type ev);
      int          pick;
      entry_type   r;
      int unsigned d, fin, wt, turn;
      ev = '0;
      if (w.op == OP_SUBMIT) begin
         if (future_fill < CAPACITY) begin
            future_q[future_fill] = '{id: w.id, arr: w.arr,
                                      trk: TRK_W'(clamp_trk(32'(w.trk)))};
            future_fill++;
         end
         return 1'b0;
      end
      if (!run_begun) begin
         head_trk = clamp_trk(32'(start_trk_reg));
         run_begun = 1'b1;
      end
      while (future_next < future_fill && future_q[future_next].arr <= now_t) begin
         if (policy_reg == POL_FLOOK) staged_q[staged_cnt++] = future_q[future_next];
         else active_q[active_cnt++] = future_q[future_next];
         future_next++;
      end
      if (active_cnt == 0 && staged_cnt != 0) begin
         for (int i = 0; i < staged_cnt; i++) active_q[i] = staged_q[i];
         active_cnt = staged_cnt;
         staged_cnt = 0;
      end
      ev.from_track = TRK_W'(head_trk);
      ev.to_track = TRK_W'(head_trk);
      ev.start_time = TIME_W'(now_t);
      if (active_cnt == 0) begin
         if (future_next >= future_fill) begin
            ev.outcome = OUT_FINISHED;
            ev.end_time = TIME_W'(now_t);
         end else begin
            ev.outcome = OUT_IDLE;
            ev.end_time = TIME_W'(future_q[future_next].arr);
            now_t = 32'(future_q[future_next].arr);
         end
      end else begin
         case (policy_reg)
            POL_SSTF: pick = closest_request(1'b0);
            POL_LOOK, POL_FLOOK: begin
               pick = closest_request(1'b1);
               if (pick < 0) begin
                  heading_down = !heading_down;
                  pick = closest_request(1'b1);
               end
            end
            POL_CLOOK: begin
               pick = closest_request(1'b1);
               if (pick < 0) begin
                  pick = 0;
                  for (int i = 1; i < active_cnt; i++)
                     if (active_q[i].trk < active_q[pick].trk) pick = i;
               end
            end
            default: pick = 0;
         endcase
         if (pick < 0) pick = 0;
         r = active_q[pick];
         for (int i = pick; i + 1 < active_cnt; i++) active_q[i] = active_q[i + 1];
         active_cnt--;
         d = gap(head_trk, 32'(r.trk));
         fin = sat_sum(now_t, d, TIME_SAT);
         wt = (now_t >= 32'(r.arr)) ? now_t - 32'(r.arr) : 0;
         turn = (fin >= 32'(r.arr)) ? fin - 32'(r.arr) : 0;
         move_sum = sat_sum(move_sum, d, TIME_SAT);
         wait_sum = sat_sum(wait_sum, wt, SUM_SAT);
         turn_sum = sat_sum(turn_sum, turn, SUM_SAT);
         if (wt > wait_top) wait_top = wt;
         ev.outcome = OUT_SERVICE;
         ev.served_id = r.id;
         ev.end_time = TIME_W'(fin);
         ev.to_track = r.trk;
         ev.wait_time = TIME_W'(wt);
         head_trk = 32'(r.trk);
         now_t = fin;
      end
      ev.sweep_down = heading_down;
      ev.total_movement = TIME_W'(move_sum);
      ev.total_wait = SUM_W'(wait_sum);
      ev.total_turnaround = SUM_W'(turn_sum);
      ev.max_wait_seen = TIME_W'(wait_top);
      return 1'b1;
   endfunction

   task automatic check_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
         fails++;
      end
   endtask

   // Monitor, predictor and watchdog; everything is sampled at the rising edge.
   always @(posedge clock) begin
      rsp_type ev;
      word_type w;
      word_taken = !reset && start && !busy;
      csr_taken = !reset && csr_valid && csr_ready;
      if (!reset && rsp_strobe) begin
         if (expected_events.size() == 0) begin
            $display("%0t: event word with none expected, outcome %0d", $time,
                     seen.outcome);
            fails++;
         end else begin
            ev = expected_events.pop_front();
            check_field("outcome", ev.outcome, seen.outcome);
            check_field("served_id", ev.served_id, seen.served_id);
            check_field("start_time", ev.start_time, seen.start_time);
            check_field("end_time", ev.end_time, seen.end_time);
            check_field("from_track", ev.from_track, seen.from_track);
            check_field("to_track", ev.to_track, seen.to_track);
            check_field("wait_time", ev.wait_time, seen.wait_time);
            check_field("sweep_down", ev.sweep_down, seen.sweep_down);
            check_field("total_movement", ev.total_movement, seen.total_movement);
            check_field("total_wait", ev.total_wait, seen.total_wait);
            check_field("total_turnaround", ev.total_turnaround, seen.total_turnaround);
            check_field("max_wait_seen", ev.max_wait_seen, seen.max_wait_seen);
         end
      end
      if (word_taken) begin
         w = '{op: req_operation, id: req_request_id, arr: req_arrival_time,
               trk: req_request_track};
         if (schedule_word(w, ev)) expected_events.insert(expected_events.size(), ev);
      end
      if (word_taken || csr_taken || (!reset && rsp_strobe) || reset) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= WATCHDOG) begin
         $display("disk_head_request_scheduler_tb NOT OK");
         $finish;
      end
   end

   // Driver: a word stays on the ports until it is taken.
   always @(negedge clock) begin
      word_type w;
      if (!reset && !(start && !word_taken)) begin
         if (pending_words.size() != 0 && $urandom_range(99) >= idle_pct) begin
            w = pending_words.pop_front();
            start <= 1'b1;
            req_operation <= w.op;
            req_request_id <= w.id;
            req_arrival_time <= w.arr;
            req_request_track <= w.trk;
         end else begin
            start <= 1'b0;
         end
      end
   end

   task automatic write_csr(logic idx, logic [TRK_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(negedge clock); while (!csr_taken);
      csr_valid <= 1'b0;
      if (idx == REG_POLICY) policy_reg = data[POL_W-1:0];
      else start_trk_reg = data;
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_words.size() != 0 || start || expected_events.size() != 0 || busy);
      repeat (30) @(negedge clock);
   endtask

   task automatic queue_word(logic op, int unsigned id, int unsigned arr, int unsigned trk);
      word_type w;
      w.op = op;
      w.id = ID_W'(id);
      w.arr = ARR_W'(arr);
      w.trk = TRK_W'(trk);
      pending_words.insert(pending_words.size(), w);
   endtask

   initial begin
      int unsigned next_arr;
      int          n_sub;
      logic [POL_W-1:0] pol;
      next_arr = 0;
      future_fill = 0; future_next = 0; active_cnt = 0; staged_cnt = 0;
      head_trk = 0; now_t = 0; move_sum = 0; wait_sum = 0; turn_sum = 0; wait_top = 0;
      heading_down = 1'b0;
      run_begun = 1'b0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      for (int ph = 0; ph < 10; ph++) begin
         idle_pct = (ph < 3) ? 9 : (ph < 6) ? 87 : 0;
         case (ph)
            0: pol = POL_SSTF;
            1: pol = POL_FIFO;
            2: pol = POL_LOOK;
            3: pol = POL_CLOOK;
            4: pol = POL_FLOOK;
            5: pol = 3'd5;
            6: pol = 3'd6;
            7: pol = 3'd7;
            8: pol = POL_FLOOK;
            default: pol = POL_LOOK;
         endcase
         write_csr(REG_POLICY, {(TRK_W - POL_W)'($urandom), pol});
         write_csr(REG_START_TRACK, (ph == 0) ? 14'h3FFF :
                                    (ph == 9) ? 14'd0 : TRK_W'($urandom));
         if (ph == 0) begin
            // Track extremes, an oversized track and ties at equal distance.
            queue_word(OP_SUBMIT, 0, 0, 0);
            queue_word(OP_SUBMIT, 127, 0, 16383);
            queue_word(OP_SUBMIT, 5, 0, 9999);
            queue_word(OP_SUBMIT, 127, 0, 9999);
            queue_word(OP_STEP, 0, 0, 0);
            queue_word(OP_SUBMIT, 9, 40, 5000);
            queue_word(OP_SUBMIT, 10, 40, 5000);
            queue_word(OP_SUBMIT, 11, 60000, 1);
            next_arr = 60000;
            repeat (12) queue_word(OP_STEP, $urandom, $urandom, $urandom);
         end
         n_sub = (ph == 9) ? 30 : 13;
         for (int k = 0; k < n_sub; k++) begin
            next_arr += $urandom_range(0, 900);
            if (next_arr > ARR_TOP || (ph == 9 && k == n_sub - 1)) next_arr = ARR_TOP;
            queue_word(OP_SUBMIT, $urandom_range(0, 127), next_arr,
                       $urandom_range(0, 16383));
            repeat ($urandom_range(0, 3)) queue_word(OP_STEP, $urandom, $urandom, $urandom);
         end
         repeat ($urandom_range(130, 155)) queue_word(OP_STEP, $urandom, $urandom, $urandom);
         // A submit after the run has finished must be picked up by later steps.
         if (ph == 9) begin
            queue_word(OP_SUBMIT, 3, ARR_TOP, 9999);
            repeat (5) queue_word(OP_STEP, 0, 0, 0);
         end
         wait_drained();
      end
      if (fails == 0) $display("disk_head_request_scheduler_tb OK");
      else $display("disk_head_request_scheduler_tb NOT OK");
      $finish;
   end
endmodule
